@@ rtl/core/bamd_pkg.sv @@
// Package of shared types, codes and the I/O device table of the address map decoder.
`timescale 1ns / 1ps

package bamd_pkg;

    localparam int RomBankBitsDefault = 7;
    localparam int ExtRamBankBitsDefault = 2;
    localparam int RomBankW = 7;
    localparam int ExtBankW = 2;
    localparam int OffsetW = 21;
    localparam int CfgIndexW = 2;
    localparam int CfgDataW = 3;

    typedef enum logic [3:0] {
        RG_NONE    = 4'd0,
        RG_ROM     = 4'd1,
        RG_VRAM    = 4'd2,
        RG_ERAM    = 4'd3,
        RG_WRAM    = 4'd4,
        RG_OAM     = 4'd5,
        RG_IO      = 4'd6,
        RG_HRAM    = 4'd7,
        RG_IE      = 4'd8,
        RG_BANKREG = 4'd9
    } t_region;

    typedef enum logic [2:0] {
        IO_NONE    = 3'd0,
        IO_JOYPAD  = 3'd1,
        IO_SERIAL  = 3'd2,
        IO_TIMER   = 3'd3,
        IO_CPU     = 3'd4,
        IO_AUDIO   = 3'd5,
        IO_DISPLAY = 3'd6
    } t_io_dev;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_BANKING_ENABLED = 2'd0,
        CFG_EXT_RAM_PRESENT = 2'd1,
        CFG_VIDEO_BANK      = 2'd2,
        CFG_WORK_BANK       = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        BR_RAM_ENABLE = 2'd0,
        BR_LOW_BITS   = 2'd1,
        BR_HIGH_BITS  = 2'd2,
        BR_MODE       = 2'd3
    } t_bank_reg;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_opcode;

    typedef struct packed {
        logic        opcode;
        logic [15:0] bus_address;
        logic [7:0]  write_byte;
    } t_in_item;

    typedef struct packed {
        t_region              region;
        logic [OffsetW-1:0]   region_offset;
        t_io_dev              io_device;
        logic [6:0]           io_index;
        logic                 store_write;
        logic                 read_zero;
        logic [RomBankW-1:0]  rom_bank_now;
    } t_out_item;

    typedef struct packed {
        logic       banking_enabled;
        logic       ext_ram_present;
        logic       video_bank;
        logic [2:0] work_bank;
    } t_cfg;

    typedef struct packed {
        logic [4:0] low_bits;
        logic [1:0] high_bits;
        logic       ram_mode;
    } t_bank_state;

    function automatic t_io_dev io_class(input logic [6:0] idx);
        t_io_dev dev;
        case (idx) inside
            7'h00:                         dev = IO_JOYPAD;
            [7'h01:7'h02]:                 dev = IO_SERIAL;
            [7'h04:7'h07]:                 dev = IO_TIMER;
            7'h0F, 7'h4D:                  dev = IO_CPU;
            [7'h10:7'h14], [7'h16:7'h1E],
            [7'h20:7'h26], [7'h30:7'h3F]:  dev = IO_AUDIO;
            [7'h40:7'h4B]:                 dev = IO_DISPLAY;
            default:                       dev = IO_NONE;
        endcase
        return dev;
    endfunction

endpackage

@@ rtl/core/bamd_decode.sv @@
// Combinational decode of one access: region, offset, device class and bank register update.
`timescale 1ns / 1ps

module bamd_decode import bamd_pkg::*; #(
    parameter int ROM_BANK_BITS     = RomBankBitsDefault,
    parameter int EXT_RAM_BANK_BITS = ExtRamBankBitsDefault
) (
    input  t_in_item    i_item,
    input  t_cfg        i_cfg,
    input  t_bank_state i_bank,
    output t_bank_state o_bank_next,
    output t_out_item   o_result
);

    localparam logic [RomBankW-1:0] RomMask = RomBankW'((1 << ROM_BANK_BITS) - 1);
    localparam logic [ExtBankW-1:0] ExtMask = ExtBankW'((1 << EXT_RAM_BANK_BITS) - 1);

    logic [15:0]         addr;
    logic                wr;
    logic                bank_write;
    logic [4:0]          low_data;
    logic [RomBankW-1:0] rom_bank;
    logic [ExtBankW-1:0] ext_bank;
    logic [2:0]          work_bank;
    t_bank_state         n_bank;
    t_out_item           res;

    always_comb begin
        addr = i_item.bus_address;
        if (addr inside {[16'hE000:16'hFDFF]}) begin
            addr[13] = 1'b0;
        end
    end

    assign wr = i_item.opcode == OP_WRITE;
    assign bank_write = wr && i_cfg.banking_enabled && !addr[15];
    assign low_data = i_item.write_byte[4:0];

    always_comb begin
        n_bank = i_bank;
        if (bank_write) begin
            case (t_bank_reg'(addr[14:13]))
                BR_LOW_BITS:  n_bank.low_bits = (low_data == 5'd0) ? 5'd1 : low_data;
                BR_HIGH_BITS: n_bank.high_bits = i_item.write_byte[1:0];
                BR_MODE:      n_bank.ram_mode = i_item.write_byte[0];
                default:      n_bank = i_bank;
            endcase
        end
    end

    // Only bank register writes change the state, so the post-access bank serves ROM reads too.
    assign rom_bank = (n_bank.ram_mode ? {2'b00, n_bank.low_bits}
                                       : {n_bank.high_bits, n_bank.low_bits}) & RomMask;
    assign ext_bank = (i_bank.ram_mode ? i_bank.high_bits : 2'b00) & ExtMask;
    assign work_bank = (i_cfg.work_bank == 3'd0) ? 3'd1 : i_cfg.work_bank;

    always_comb begin
        res = '0;
        res.region = RG_NONE;
        res.io_device = IO_NONE;
        case (addr) inside
            [16'h0000:16'h7FFF]: begin
                if (bank_write) begin
                    res.region = RG_BANKREG;
                    res.region_offset = OffsetW'(addr[14:13]);
                end else begin
                    res.region = RG_ROM;
                    if (!addr[14]) begin
                        res.region_offset = OffsetW'(addr[13:0]);
                    end else begin
                        res.region_offset = {rom_bank, addr[13:0]};
                    end
                end
            end
            [16'h8000:16'h9FFF]: begin
                res.region = RG_VRAM;
                res.region_offset = OffsetW'({i_cfg.video_bank, addr[12:0]});
                res.store_write = wr;
            end
            [16'hA000:16'hBFFF]: begin
                if (i_cfg.ext_ram_present) begin
                    res.region = RG_ERAM;
                    res.region_offset = OffsetW'({ext_bank, addr[12:0]});
                    res.store_write = wr;
                end else begin
                    res.read_zero = !wr;
                end
            end
            [16'hC000:16'hCFFF]: begin
                res.region = RG_WRAM;
                res.region_offset = OffsetW'(addr[11:0]);
                res.store_write = wr;
            end
            [16'hD000:16'hDFFF]: begin
                res.region = RG_WRAM;
                res.region_offset = OffsetW'({work_bank, addr[11:0]});
                res.store_write = wr;
            end
            [16'hFE00:16'hFE9F]: begin
                res.region = RG_OAM;
                res.region_offset = OffsetW'(addr[7:0]);
                res.store_write = wr;
            end
            [16'hFF00:16'hFF7F]: begin
                res.region = RG_IO;
                res.io_index = addr[6:0];
                res.io_device = io_class(addr[6:0]);
                res.region_offset = OffsetW'(addr[6:0]);
                res.read_zero = !wr && (res.io_device == IO_NONE);
            end
            [16'hFF80:16'hFFFE]: begin
                res.region = RG_HRAM;
                res.region_offset = OffsetW'(addr[6:0]);
                res.store_write = wr;
            end
            16'hFFFF: begin
                res.region = RG_IE;
            end
            default: begin
                res.read_zero = !wr;
            end
        endcase
        res.rom_bank_now = rom_bank;
    end

    assign o_bank_next = n_bank;
    assign o_result = res;

endmodule

@@ rtl/core/banked_address_map_decoder.sv @@
// Top level of the banked address map decoder with MBC1 bank registers.
// The block decodes one CPU byte access per item on the input channel
// (opcode, bus address, write data) into a region, a byte offset inside
// the bank in use, the I/O device class and the ROM bank mapped at 0x4000.
// Writes below 0x8000 go to the bank registers when banking is enabled; those below 0x2000 change no state.
// An item is held in the input register, decoded combinationally and lands
// in the output register, from which its result is offered. Both stages
// advance together, so one item per cycle is sustained while the receiver
// takes results. When the receiver stalls, the output register holds its
// result and one more item can wait in the input register; ready then
// falls until the receiver takes the held result.
// The configuration channel is always ready and registers each valid write.
// Reset clears both stages, restores the configuration registers to their
// defaults and sets the bank registers to low bank 1, high bits 0, mode 0.
`timescale 1ns / 1ps

module banked_address_map_decoder import bamd_pkg::*; #(
    parameter int ROM_BANK_BITS     = RomBankBitsDefault,
    parameter int EXT_RAM_BANK_BITS = ExtRamBankBitsDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  t_cfg_index           i_cfg_index,
    input  logic [CfgDataW-1:0]  i_cfg_data
);

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;
    t_cfg        r_cfg;
    t_bank_state r_bank;
    t_bank_state n_bank;
    t_out_item   n_out;
    logic        advance;
    logic        out_free;

    assign out_free = !r_out_valid || i_out_ready;
    assign advance = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item = r_out;
    assign o_cfg_ready = 1'b1;

    bamd_decode #(
        .ROM_BANK_BITS     (ROM_BANK_BITS),
        .EXT_RAM_BANK_BITS (EXT_RAM_BANK_BITS)
    ) u_decode (
        .i_item      (r_in),
        .i_cfg       (r_cfg),
        .i_bank      (r_bank),
        .o_bank_next (n_bank),
        .o_result    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_bank.low_bits <= 5'd1;
            r_bank.high_bits <= 2'd0;
            r_bank.ram_mode <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_bank <= n_bank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.banking_enabled <= 1'b1;
            r_cfg.ext_ram_present <= 1'b0;
            r_cfg.video_bank <= 1'b0;
            r_cfg.work_bank <= 3'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BANKING_ENABLED: r_cfg.banking_enabled <= i_cfg_data[0];
                CFG_EXT_RAM_PRESENT: r_cfg.ext_ram_present <= i_cfg_data[0];
                CFG_VIDEO_BANK:      r_cfg.video_bank <= i_cfg_data[0];
                CFG_WORK_BANK:       r_cfg.work_bank <= i_cfg_data;
                default:             r_cfg <= r_cfg;
            endcase
        end
    end

    a_low_bank_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bank.low_bits != 5'd0)
        else $error("Low bank field holds zero.");

    a_io_fields_only_for_io: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.region != RG_IO |->
            r_out.io_device == IO_NONE && r_out.io_index == 7'd0)
        else $error("I/O fields set outside the I/O region.");

    a_unmapped_is_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.region == RG_NONE |->
            r_out.region_offset == '0 && !r_out.store_write)
        else $error("Unmapped access carries an offset or a store write.");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && r_out_valid && !i_out_ready)
        else $error("Input stalled while the pipeline had room.");

    a_bank_holds_without_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_bank))
        else $error("Bank registers changed without a decoded item.");

endmodule

@@ tb/banked_address_map_decoder_test.sv @@
// Self-checking testbench of the banked address map decoder with a built-in decode predictor.
`timescale 1ns / 1ps

module banked_address_map_decoder_test;
    import bamd_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int DirRows = 25;
    localparam int HoldCycles = 60;

    localparam bit [2:0] IoDeviceMap [128] = '{
        1, 2, 2, 0, 3, 3, 3, 3, 0, 0, 0, 0, 0, 0, 0, 4,
        5, 5, 5, 5, 5, 0, 5, 5, 5, 5, 5, 5, 5, 5, 5, 0,
        5, 5, 5, 5, 5, 5, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0,
        5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5, 5,
        6, 6, 6, 6, 6, 6, 6, 6, 6, 6, 6, 6, 0, 4, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
    };

    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item want;
    } t_dir_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    t_in_item            i_in_item;
    logic                o_out_valid;
    logic                i_out_ready;
    t_out_item           o_out_item;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    t_cfg_index          i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_data;

    t_cfg        cfg_now;
    t_bank_state bank_now;
    t_out_item   expected_decodes [$];
    t_out_item   head_decode;
    t_dir_row    dir_table [DirRows];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          rx_idle_on = 1'b0;
    bit          rx_hold_req = 1'b0;

    banked_address_map_decoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [RomBankW-1:0] mapped_rom_bank();
        logic [RomBankW-1:0] b;
        b = bank_now.ram_mode ? {2'b00, bank_now.low_bits}
                              : {bank_now.high_bits, bank_now.low_bits};
        return b & RomBankW'((1 << RomBankBitsDefault) - 1);
    endfunction

    function automatic logic [ExtBankW-1:0] mapped_eram_bank();
        logic [ExtBankW-1:0] b;
        b = bank_now.ram_mode ? bank_now.high_bits : 2'b00;
        return b & ExtBankW'((1 << ExtRamBankBitsDefault) - 1);
    endfunction

    function automatic t_out_item decode_access(input t_in_item it);
        t_out_item   r;
        logic [15:0] a;
        logic [6:0]  idx;
        logic [2:0]  wb;
        r = '0;
        a = it.bus_address;
        if (a >= 16'hE000 && a < 16'hFE00) begin
            a = a - 16'h2000;
        end
        if (a < 16'h8000) begin
            if (it.opcode == OP_WRITE && cfg_now.banking_enabled) begin
                r.region = RG_BANKREG;
                r.region_offset = OffsetW'(a[14:13]);
                case (t_bank_reg'(a[14:13]))
                    BR_LOW_BITS: begin
                        bank_now.low_bits = (it.write_byte[4:0] == 5'd0) ? 5'd1
                                                                         : it.write_byte[4:0];
                    end
                    BR_HIGH_BITS: bank_now.high_bits = it.write_byte[1:0];
                    BR_MODE: bank_now.ram_mode = it.write_byte[0];
                    default: ;
                endcase
            end else begin
                r.region = RG_ROM;
                if (a < 16'h4000) begin
                    r.region_offset = OffsetW'(a);
                end else begin
                    r.region_offset = {mapped_rom_bank(), a[13:0]};
                end
            end
        end else if (a < 16'hA000) begin
            r.region = RG_VRAM;
            r.region_offset = OffsetW'({cfg_now.video_bank, a[12:0]});
            r.store_write = it.opcode;
        end else if (a < 16'hC000) begin
            if (cfg_now.ext_ram_present) begin
                r.region = RG_ERAM;
                r.region_offset = OffsetW'({mapped_eram_bank(), a[12:0]});
                r.store_write = it.opcode;
            end else begin
                r.read_zero = ~it.opcode;
            end
        end else if (a < 16'hD000) begin
            r.region = RG_WRAM;
            r.region_offset = OffsetW'(a[11:0]);
            r.store_write = it.opcode;
        end else if (a < 16'hE000) begin
            wb = (cfg_now.work_bank == 3'd0) ? 3'd1 : cfg_now.work_bank;
            r.region = RG_WRAM;
            r.region_offset = OffsetW'({wb, a[11:0]});
            r.store_write = it.opcode;
        end else if (a < 16'hFEA0) begin
            r.region = RG_OAM;
            r.region_offset = OffsetW'(a[7:0]);
            r.store_write = it.opcode;
        end else if (a < 16'hFF00) begin
            r.read_zero = ~it.opcode;
        end else if (a < 16'hFF80) begin
            idx = a[6:0];
            r.region = RG_IO;
            r.io_device = t_io_dev'(IoDeviceMap[idx]);
            r.io_index = idx;
            r.region_offset = OffsetW'(idx);
            r.read_zero = (it.opcode == OP_READ && r.io_device == IO_NONE);
        end else if (a < 16'hFFFF) begin
            r.region = RG_HRAM;
            r.region_offset = OffsetW'(a[6:0]);
            r.store_write = it.opcode;
        end else begin
            r.region = RG_IE;
        end
        r.rom_bank_now = mapped_rom_bank();
        return r;
    endfunction

    function automatic t_in_item mk_in(input t_opcode op, input logic [15:0] addr,
                                       input logic [7:0] data);
        t_in_item it;
        it.opcode = op;
        it.bus_address = addr;
        it.write_byte = data;
        return it;
    endfunction

    function automatic t_out_item mk_out(input t_region rg, input int off, input t_io_dev dv,
                                         input int idx, input bit sw, input bit rz,
                                         input int rb);
        t_out_item r;
        r.region = rg;
        r.region_offset = OffsetW'(off);
        r.io_device = dv;
        r.io_index = 7'(idx);
        r.store_write = sw;
        r.read_zero = rz;
        r.rom_bank_now = RomBankW'(rb);
        return r;
    endfunction

    function automatic t_in_item random_access();
        t_in_item it;
        it.opcode = 1'($urandom_range(0, 1));
        it.write_byte = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 11))
            0, 1, 2: begin
                it.opcode = OP_WRITE;
                it.bus_address = 16'($urandom_range(16'h0000, 16'h7FFF));
                if ($urandom_range(0, 3) == 0) begin
                    it.write_byte[4:0] = 5'd0;
                end
            end
            3: it.bus_address = 16'($urandom_range(16'h4000, 16'h7FFF));
            4: it.bus_address = 16'($urandom_range(16'h0000, 16'h3FFF));
            5: it.bus_address = 16'($urandom_range(16'h8000, 16'h9FFF));
            6: it.bus_address = 16'($urandom_range(16'hA000, 16'hBFFF));
            7: it.bus_address = 16'($urandom_range(16'hC000, 16'hDFFF));
            8: it.bus_address = 16'($urandom_range(16'hE000, 16'hFDFF));
            9: it.bus_address = 16'($urandom_range(16'hFE00, 16'hFEFF));
            10: it.bus_address = 16'($urandom_range(16'hFF00, 16'hFFFF));
            default: it.bus_address = 16'($urandom_range(0, 16'hFFFF));
        endcase
        return it;
    endfunction

    task automatic send_access(input t_in_item it, input logic typed, input t_out_item want);
        t_out_item pred;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_item = it;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) break;
        end
        pred = decode_access(it);
        expected_decodes.push_back(typed ? want : pred);
    endtask

    task automatic pause_sender(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
    endtask

    task automatic drain_decodes();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_decodes.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_cfg(input t_cfg_index idx, input logic [CfgDataW-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        case (idx)
            CFG_BANKING_ENABLED: cfg_now.banking_enabled = data[0];
            CFG_EXT_RAM_PRESENT: cfg_now.ext_ram_present = data[0];
            CFG_VIDEO_BANK: cfg_now.video_bank = data[0];
            CFG_WORK_BANK: cfg_now.work_bank = data[2:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic run_phase(input bit be, input bit er, input bit vb, input logic [2:0] wb,
                             input int n, input bit idle, input bit hold);
        drain_decodes();
        write_cfg(CFG_BANKING_ENABLED, {2'($urandom_range(0, 3)), be});
        write_cfg(CFG_EXT_RAM_PRESENT, {2'($urandom_range(0, 3)), er});
        write_cfg(CFG_VIDEO_BANK, {2'($urandom_range(0, 3)), vb});
        write_cfg(CFG_WORK_BANK, wb);
        rx_idle_on = idle;
        if (hold) begin
            rx_hold_req = 1'b1;
        end
        repeat (n) begin
            send_access(random_access(), 1'b0, '0);
            if (idle && $urandom_range(0, 5) == 0) begin
                pause_sender(int'($urandom_range(1, 10)));
            end
        end
    endtask

    initial begin : receiver
        int rx_gap;
        int rx_hold;
        rx_gap = 0;
        rx_hold = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_hold = HoldCycles;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_out_ready = 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_out_ready = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                rx_gap = int'($urandom_range(1, 10)) - 1;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_decodes.size() == 0) begin
                $error("result item with no expected decode pending");
                mismatch_count++;
            end else begin
                head_decode = expected_decodes.pop_front();
                if (o_out_item.region !== head_decode.region) begin
                    $error("region: expected %0d, got %0d",
                           head_decode.region, o_out_item.region);
                    mismatch_count++;
                end
                if (o_out_item.region_offset !== head_decode.region_offset) begin
                    $error("region_offset: expected 0x%0h, got 0x%0h",
                           head_decode.region_offset, o_out_item.region_offset);
                    mismatch_count++;
                end
                if (o_out_item.io_device !== head_decode.io_device) begin
                    $error("io_device: expected %0d, got %0d",
                           head_decode.io_device, o_out_item.io_device);
                    mismatch_count++;
                end
                if (o_out_item.io_index !== head_decode.io_index) begin
                    $error("io_index: expected %0d, got %0d",
                           head_decode.io_index, o_out_item.io_index);
                    mismatch_count++;
                end
                if (o_out_item.store_write !== head_decode.store_write) begin
                    $error("store_write: expected %0d, got %0d",
                           head_decode.store_write, o_out_item.store_write);
                    mismatch_count++;
                end
                if (o_out_item.read_zero !== head_decode.read_zero) begin
                    $error("read_zero: expected %0d, got %0d",
                           head_decode.read_zero, o_out_item.read_zero);
                    mismatch_count++;
                end
                if (o_out_item.rom_bank_now !== head_decode.rom_bank_now) begin
                    $error("rom_bank_now: expected %0d, got %0d",
                           head_decode.rom_bank_now, o_out_item.rom_bank_now);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("banked_address_map_decoder: mismatch");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_BANKING_ENABLED;
        i_cfg_data = '0;
        cfg_now = '{banking_enabled: 1'b1, ext_ram_present: 1'b0, video_bank: 1'b0,
                    work_bank: 3'd1};
        bank_now = '{low_bits: 5'd1, high_bits: 2'd0, ram_mode: 1'b0};

        // The first rows assume the reset values of configuration and bank state.
        dir_table = '{
            '{mk_in(OP_READ, 16'h0000, 8'h00), 1'b1,
              mk_out(RG_ROM, 'h0, IO_NONE, 0, 0, 0, 1)},
            '{mk_in(OP_READ, 16'h7FFF, 8'hFF), 1'b1,
              mk_out(RG_ROM, 'h7FFF, IO_NONE, 0, 0, 0, 1)},
            '{mk_in(OP_READ, 16'hA000, 8'h00), 1'b1,
              mk_out(RG_NONE, 'h0, IO_NONE, 0, 0, 1, 1)},
            '{mk_in(OP_WRITE, 16'hBFFF, 8'h5A), 1'b1,
              mk_out(RG_NONE, 'h0, IO_NONE, 0, 0, 0, 1)},
            '{mk_in(OP_READ, 16'hFEA0, 8'h00), 1'b1,
              mk_out(RG_NONE, 'h0, IO_NONE, 0, 0, 1, 1)},
            '{mk_in(OP_READ, 16'hFF03, 8'h00), 1'b1,
              mk_out(RG_IO, 'h3, IO_NONE, 3, 0, 1, 1)},
            '{mk_in(OP_WRITE, 16'hFF00, 8'h3C), 1'b1,
              mk_out(RG_IO, 'h0, IO_JOYPAD, 0, 0, 0, 1)},
            '{mk_in(OP_READ, 16'hFFFF, 8'h00), 1'b1,
              mk_out(RG_IE, 'h0, IO_NONE, 0, 0, 0, 1)},
            '{mk_in(OP_WRITE, 16'hFFFE, 8'hFF), 1'b1,
              mk_out(RG_HRAM, 'h7E, IO_NONE, 0, 1, 0, 1)},
            '{mk_in(OP_WRITE, 16'h2000, 8'h00), 1'b1,
              mk_out(RG_BANKREG, 'h1, IO_NONE, 0, 0, 0, 1)},
            '{mk_in(OP_WRITE, 16'h3FFF, 8'hFF), 1'b1,
              mk_out(RG_BANKREG, 'h1, IO_NONE, 0, 0, 0, 'h1F)},
            '{mk_in(OP_WRITE, 16'h4000, 8'hFF), 1'b1,
              mk_out(RG_BANKREG, 'h2, IO_NONE, 0, 0, 0, 'h7F)},
            '{mk_in(OP_READ, 16'h4000, 8'h00), 1'b1,
              mk_out(RG_ROM, 'h1FC000, IO_NONE, 0, 0, 0, 'h7F)},
            '{mk_in(OP_READ, 16'h7FFF, 8'h00), 1'b1,
              mk_out(RG_ROM, 'h1FFFFF, IO_NONE, 0, 0, 0, 'h7F)},
            '{mk_in(OP_WRITE, 16'h6000, 8'h01), 1'b0, '0},
            '{mk_in(OP_WRITE, 16'h0000, 8'hA5), 1'b0, '0},
            '{mk_in(OP_READ, 16'hE000, 8'h00), 1'b0, '0},
            '{mk_in(OP_WRITE, 16'hFDFF, 8'h5A), 1'b0, '0},
            '{mk_in(OP_READ, 16'h8000, 8'h00), 1'b0, '0},
            '{mk_in(OP_WRITE, 16'h9FFF, 8'h00), 1'b0, '0},
            '{mk_in(OP_READ, 16'hFE00, 8'h00), 1'b0, '0},
            '{mk_in(OP_WRITE, 16'hFE9F, 8'h77), 1'b0, '0},
            '{mk_in(OP_READ, 16'hFF7F, 8'h00), 1'b0, '0},
            '{mk_in(OP_READ, 16'hFF4D, 8'h00), 1'b0, '0},
            '{mk_in(OP_WRITE, 16'h6000, 8'hFE), 1'b0, '0}
        };

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        rx_idle_on = 1'b1;
        foreach (dir_table[i]) begin
            send_access(dir_table[i].item, dir_table[i].typed, dir_table[i].want);
            if ($urandom_range(0, 3) == 0) begin
                pause_sender(int'($urandom_range(1, 10)));
            end
        end

        run_phase(1'b1, 1'b1, 1'b1, 3'd7, 300, 1'b1, 1'b0);
        run_phase(1'b0, 1'b0, 1'b0, 3'd0, 200, 1'b1, 1'b1);
        run_phase(1'b1, 1'b1, 1'b0, 3'd1, 300, 1'b1, 1'b1);
        repeat (3) begin
            run_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), 150, 1'b1, 1'b0);
        end
        run_phase(1'b1, 1'b1, 1'b1, 3'd4, 200, 1'b0, 1'b0);

        drain_decodes();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("banked_address_map_decoder: match");
        end else begin
            $display("banked_address_map_decoder: mismatch");
        end
        $finish;
    end

endmodule
